// ===== sv/fmbq_pkg.sv =====
// Shared types and constants for the front/middle/back queue.
package fmbq_pkg;

    // Default number of words the queue can hold
    localparam int unsigned CAPACITY_DEF = 64;

    // Field widths fixed by the interface
    localparam int unsigned WORD_W = 32;
    localparam int unsigned CMD_W  = 3;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OCC_W  = 7;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT  = 3'd0,
        CMD_PUSH_MIDDLE = 3'd1,
        CMD_PUSH_BACK   = 3'd2,
        CMD_POP_FRONT   = 3'd3,
        CMD_POP_MIDDLE  = 3'd4,
        CMD_POP_BACK    = 3'd5
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Shift operation broadcast along the row of cells
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_shift_op;

endpackage

// ===== sv/fmbq_cell.sv =====
// One storage cell of the queue: holds a word and shifts with its neighbours.
module fmbq_cell #(
    parameter int unsigned INDEX = 0,
    parameter int unsigned CW    = 7
) (
    input  logic                        i_clk,
    input  fmbq_pkg::t_shift_op         i_op,
    input  logic [CW-1:0]               i_pos,
    input  logic [fmbq_pkg::WORD_W-1:0] i_word,
    input  logic [fmbq_pkg::WORD_W-1:0] i_prev,
    input  logic [fmbq_pkg::WORD_W-1:0] i_next,
    output logic [fmbq_pkg::WORD_W-1:0] o_word,
    output logic [fmbq_pkg::WORD_W-1:0] o_tap
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic [fmbq_pkg::WORD_W-1:0] r_word;
    logic [fmbq_pkg::WORD_W-1:0] n_word;

    // Pick the new content from the broadcast operation and this cell's place
    always_comb begin
        n_word = r_word;
        unique case (i_op)
            fmbq_pkg::OP_INSERT: begin
                if (IDX == i_pos) begin
                    n_word = i_word;
                end else if (IDX > i_pos) begin
                    n_word = i_prev;
                end
            end
            fmbq_pkg::OP_REMOVE: begin
                if (IDX >= i_pos) begin
                    n_word = i_next;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // Drive the word onto the read bus only when this cell is addressed
    assign o_word = r_word;
    assign o_tap  = (IDX == i_pos) ? r_word : '0;

endmodule

// ===== sv/front_middle_back_queue.sv =====
// Top level of the front/middle/back queue built from a row of shifting cells.
//
// An ordered store of up to CAPACITY signed 32-bit words, one cell per word.
// Each accepted command (push or pop at front, middle or back) shifts the
// whole row at once, so one command is taken per clock while the input is
// not stalled, and its result word appears in the output register in the
// next cycle. The input stalls only while a finished result is held in the
// output register and the consumer stalls it. Push middle inserts at
// count/2, pop middle removes (count-1)/2. Pop on an empty store gives -1
// with status empty; push on a full store is refused with status full.
// Occupancy carries the low 7 bits of the word count after the command.
// Storage needs no clearing after reset.
module front_middle_back_queue #(
    parameter int unsigned CAPACITY = fmbq_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [fmbq_pkg::CMD_W-1:0]         i_cmd,
    input  logic signed [fmbq_pkg::WORD_W-1:0] i_push_value,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [fmbq_pkg::WORD_W-1:0] o_pop_value,
    output logic [fmbq_pkg::STAT_W-1:0]        o_status,
    output logic [fmbq_pkg::OCC_W-1:0]         o_occupancy
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    logic                        accept;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               n_count;
    fmbq_pkg::t_shift_op         op;
    logic [CW-1:0]               pos;
    fmbq_pkg::t_status           status;
    logic                        is_pop;
    logic [fmbq_pkg::WORD_W-1:0] read_word;
    logic [fmbq_pkg::WORD_W-1:0] res_word;

    logic [fmbq_pkg::WORD_W-1:0] words [CAPACITY];
    logic [fmbq_pkg::WORD_W-1:0] taps  [CAPACITY];

    logic                        r_out_valid;
    logic [fmbq_pkg::WORD_W-1:0] r_out_value;
    fmbq_pkg::t_status           r_out_status;
    logic [CW-1:0]               r_out_count;

    // Take a word whenever the output register is free or being emptied
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // Decode the command into a shift operation and position
    always_comb begin
        op     = fmbq_pkg::OP_HOLD;
        pos    = '0;
        status = fmbq_pkg::ST_OK;
        is_pop = 1'b0;
        unique case (i_cmd)
            fmbq_pkg::CMD_PUSH_FRONT,
            fmbq_pkg::CMD_PUSH_MIDDLE,
            fmbq_pkg::CMD_PUSH_BACK: begin
                if (r_count >= FULL_CNT) begin
                    status = fmbq_pkg::ST_FULL;
                end else begin
                    op = fmbq_pkg::OP_INSERT;
                end
                if (i_cmd == fmbq_pkg::CMD_PUSH_MIDDLE) begin
                    pos = r_count >> 1;
                end else if (i_cmd == fmbq_pkg::CMD_PUSH_BACK) begin
                    pos = r_count;
                end
            end
            fmbq_pkg::CMD_POP_FRONT,
            fmbq_pkg::CMD_POP_MIDDLE,
            fmbq_pkg::CMD_POP_BACK: begin
                is_pop = 1'b1;
                if (r_count == '0) begin
                    status = fmbq_pkg::ST_EMPTY;
                end else begin
                    op = fmbq_pkg::OP_REMOVE;
                end
                if (i_cmd == fmbq_pkg::CMD_POP_MIDDLE) begin
                    pos = (r_count - CW'(1)) >> 1;
                end else if (i_cmd == fmbq_pkg::CMD_POP_BACK) begin
                    pos = r_count - CW'(1);
                end
            end
            default: begin
                op = fmbq_pkg::OP_HOLD;
            end
        endcase
    end

    // Row of cells; the ends see zero beyond the row
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [fmbq_pkg::WORD_W-1:0] prev_word;
        logic [fmbq_pkg::WORD_W-1:0] next_word;

        if (g == 0) begin : g_first
            assign prev_word = '0;
        end else begin : g_inner_prev
            assign prev_word = words[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign next_word = '0;
        end else begin : g_inner_next
            assign next_word = words[g+1];
        end

        fmbq_cell #(
            .INDEX (g),
            .CW    (CW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_op   (accept ? op : fmbq_pkg::OP_HOLD),
            .i_pos  (pos),
            .i_word (i_push_value),
            .i_prev (prev_word),
            .i_next (next_word),
            .o_word (words[g]),
            .o_tap  (taps[g])
        );
    end

    // Gather the addressed word from the cell taps
    always_comb begin
        read_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            read_word = read_word | taps[i];
        end
    end

    // Form the result word and the next count
    always_comb begin
        res_word = '0;
        n_count  = r_count;
        if (op == fmbq_pkg::OP_INSERT) begin
            n_count = r_count + CW'(1);
        end else if (op == fmbq_pkg::OP_REMOVE) begin
            n_count  = r_count - CW'(1);
            res_word = read_word;
        end else if (is_pop) begin
            res_word = '1;
        end
    end

    // Advance the count and load the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_value  <= res_word;
            r_out_status <= status;
            r_out_count  <= n_count;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pop_value = r_out_value;
    assign o_status    = r_out_status;
    assign o_occupancy = fmbq_pkg::OCC_W'(r_out_count);

`ifndef NO_ASSERTIONS
    // Count never exceeds the number of cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count above capacity");

    // Count moves only when a word is taken
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_count))
        else $error("queue count changed without a command");

    // Pop on an empty store reports empty and all ones
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_pop && r_count == '0) |=>
        (r_out_status == fmbq_pkg::ST_EMPTY && r_out_value == '1 && r_count == '0))
        else $error("empty pop not reported");

    // Push on a full store is refused and leaves the count alone
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_pop && status == fmbq_pkg::ST_FULL) |=>
        (r_out_status == fmbq_pkg::ST_FULL && $stable(r_count)))
        else $error("full push not refused");

    // Output register holds a result the cycle after a command
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("result missing after command");
`endif

endmodule

// ===== tb/sv/tb_front_middle_back_queue.sv =====
// Self-checking testbench for the front/middle/back queue with a shadow word store.
`timescale 1ns / 1ps

module tb_front_middle_back_queue;

    localparam int unsigned DEPTH      = fmbq_pkg::CAPACITY_DEF;
    localparam int          CYCLE_CAP  = 200000;
    localparam int          HOLD_LEN   = 300;
    localparam int          DRAIN_WAIT = 4;

    // Command codes the block treats as no operation
    localparam logic [fmbq_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [fmbq_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic signed [fmbq_pkg::WORD_W-1:0] value;
        logic [fmbq_pkg::STAT_W-1:0]        status;
        logic [fmbq_pkg::OCC_W-1:0]         occupancy;
    } t_queue_result;

    // Shadow of the queue contents and the results still owed by the block
    class t_queue_tracker;
        logic signed [fmbq_pkg::WORD_W-1:0] shadow_words[$];
        t_queue_result                      owed_results[$];
        int                                 mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Apply an accepted command to the shadow store and queue its result
        function void note_command(logic [fmbq_pkg::CMD_W-1:0] cmd,
                                   logic signed [fmbq_pkg::WORD_W-1:0] w);
            t_queue_result r;
            int unsigned   pos;
            r.value  = '0;
            r.status = fmbq_pkg::ST_OK;
            case (cmd)
                fmbq_pkg::CMD_PUSH_FRONT,
                fmbq_pkg::CMD_PUSH_MIDDLE,
                fmbq_pkg::CMD_PUSH_BACK: begin
                    if (shadow_words.size() >= DEPTH) begin
                        r.status = fmbq_pkg::ST_FULL;
                    end else begin
                        if (cmd == fmbq_pkg::CMD_PUSH_FRONT)
                            pos = 0;
                        else if (cmd == fmbq_pkg::CMD_PUSH_MIDDLE)
                            pos = shadow_words.size() / 2;
                        else
                            pos = shadow_words.size();
                        shadow_words.insert(pos, w);
                    end
                end
                fmbq_pkg::CMD_POP_FRONT,
                fmbq_pkg::CMD_POP_MIDDLE,
                fmbq_pkg::CMD_POP_BACK: begin
                    if (shadow_words.size() == 0) begin
                        r.value  = -1;
                        r.status = fmbq_pkg::ST_EMPTY;
                    end else begin
                        if (cmd == fmbq_pkg::CMD_POP_FRONT)
                            pos = 0;
                        else if (cmd == fmbq_pkg::CMD_POP_MIDDLE)
                            pos = (shadow_words.size() - 1) / 2;
                        else
                            pos = shadow_words.size() - 1;
                        r.value = shadow_words[pos];
                        shadow_words.delete(pos);
                    end
                end
                default: ;
            endcase
            r.occupancy = fmbq_pkg::OCC_W'(shadow_words.size());
            owed_results.insert(owed_results.size(), r);
        endfunction

        // Compare a delivered result with the oldest one owed
        function void check_result(logic signed [fmbq_pkg::WORD_W-1:0] value,
                                   logic [fmbq_pkg::STAT_W-1:0] status,
                                   logic [fmbq_pkg::OCC_W-1:0] occupancy);
            t_queue_result exp_r;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with none owed: value %0d status %0d occ %0d",
                             value, status, occupancy);
                return;
            end
            exp_r = owed_results.pop_front();
            if (exp_r.value !== value || exp_r.status !== status
                    || exp_r.occupancy !== occupancy) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: expected value %0d status %0d occ %0d, got %0d %0d %0d",
                             exp_r.value, exp_r.status, exp_r.occupancy,
                             value, status, occupancy);
            end
        endfunction

        function int owed();
            return owed_results.size();
        endfunction
    endclass

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_stall;
    logic [fmbq_pkg::CMD_W-1:0]         i_cmd;
    logic signed [fmbq_pkg::WORD_W-1:0] i_push_value;
    logic                               o_valid;
    logic                               i_stall;
    logic signed [fmbq_pkg::WORD_W-1:0] o_pop_value;
    logic [fmbq_pkg::STAT_W-1:0]        o_status;
    logic [fmbq_pkg::OCC_W-1:0]         o_occupancy;

    t_queue_tracker tracker = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;
    int cycle_count   = 0;

    front_middle_back_queue uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at random, or hold off for a long stretch on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Check delivered words first, then note accepted ones
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                tracker.check_result(o_pop_value, o_status, o_occupancy);
            if (i_valid && !o_stall)
                tracker.note_command(i_cmd, i_push_value);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one command word, with random idle gaps, and hold it until taken
    task automatic send_command(input logic [fmbq_pkg::CMD_W-1:0] c,
                                input logic signed [fmbq_pkg::WORD_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= c;
        i_push_value <= v;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (tracker.owed() != 0);
    endtask

    function automatic logic signed [fmbq_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return -1;
            3:       return 0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly pushes or pops as push_pct says, with the odd spare code
    function automatic logic [fmbq_pkg::CMD_W-1:0] pick_command(int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return ($urandom_range(1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
        if (r < 3 + push_pct) begin
            case ($urandom_range(2))
                0:       return fmbq_pkg::CMD_PUSH_FRONT;
                1:       return fmbq_pkg::CMD_PUSH_MIDDLE;
                default: return fmbq_pkg::CMD_PUSH_BACK;
            endcase
        end
        case ($urandom_range(2))
            0:       return fmbq_pkg::CMD_POP_FRONT;
            1:       return fmbq_pkg::CMD_POP_MIDDLE;
            default: return fmbq_pkg::CMD_POP_BACK;
        endcase
    endfunction

    // Run fill, drain and mixed bursts so the store swings between empty and full
    task automatic run_random(input int count);
        int issued;
        int burst;
        int push_pct;
        issued = 0;
        while (issued < count) begin
            burst = $urandom_range(20, 120);
            case ($urandom_range(2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 48;
            endcase
            for (int k = 0; k < burst && issued < count; k++) begin
                send_command(pick_command(push_pct), pick_word());
                issued++;
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_cmd        <= fmbq_pkg::CMD_PUSH_FRONT;
        i_push_value <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty pops, extreme words, every command, spare codes
        send_command(fmbq_pkg::CMD_POP_FRONT, 32'sh12345678);
        send_command(fmbq_pkg::CMD_POP_MIDDLE, 0);
        send_command(fmbq_pkg::CMD_POP_BACK, -1);
        send_command(fmbq_pkg::CMD_PUSH_BACK, 32'sh7fffffff);
        send_command(fmbq_pkg::CMD_PUSH_FRONT, 32'sh80000000);
        send_command(fmbq_pkg::CMD_PUSH_MIDDLE, -1);
        send_command(fmbq_pkg::CMD_PUSH_MIDDLE, 0);
        send_command(fmbq_pkg::CMD_PUSH_BACK, 32'sh55555555);
        send_command(fmbq_pkg::CMD_PUSH_FRONT, 32'shaaaaaaaa);
        send_command(CMD_SPARE_A, 32'sh0f0f0f0f);
        send_command(CMD_SPARE_B, 32'shf0f0f0f0);
        send_command(fmbq_pkg::CMD_POP_MIDDLE, 0);
        send_command(fmbq_pkg::CMD_POP_MIDDLE, 0);
        send_command(fmbq_pkg::CMD_POP_FRONT, 0);
        send_command(fmbq_pkg::CMD_POP_BACK, 0);
        send_command(fmbq_pkg::CMD_POP_MIDDLE, 0);
        send_command(fmbq_pkg::CMD_POP_FRONT, 0);
        send_command(fmbq_pkg::CMD_POP_BACK, 0);
        send_command(fmbq_pkg::CMD_PUSH_MIDDLE, 1);
        send_command(fmbq_pkg::CMD_POP_MIDDLE, 0);
        wait_for_results();

        // Sender near full rate, receiver often stalled
        send_idle_pct = 7;
        recv_idle_pct = 68;
        run_random(500);

        // Hold the result side off, which stalls the input, and push back past full
        hold_cycles = HOLD_LEN;
        for (int k = 0; k < 70; k++)
            send_command(fmbq_pkg::CMD_PUSH_BACK, pick_word());
        wait_for_results();

        // Sender often idle, receiver rarely stalled
        send_idle_pct = 68;
        recv_idle_pct = 7;
        run_random(500);

        // Full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(500);

        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.owed() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
sv/fmbq_pkg.sv
sv/fmbq_cell.sv
sv/front_middle_back_queue.sv
tb/sv/tb_front_middle_back_queue.sv
